// File: src/conv3x3_clamp_u8_assert.svh
// Assertion macros shared by the 3x3 convolution block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef CONV3X3_CLAMP_U8_ASSERT_SVH
`define CONV3X3_CLAMP_U8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C3C_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c3c assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define C3C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c3c assertion failed");

`endif

// File: src/c3c_pkg.sv
// Shared constants, types and register codes of the 3x3 convolution block.
// Used by the cell, output and top-level modules and the testbench; depends on nothing.
package c3c_pkg;

    localparam int IMAGE_WIDTH    = 64;
    localparam int IMAGE_HEIGHT   = 64;
    localparam int COEF_FRAC_BITS = 8;

    localparam int COL_W        = $clog2(IMAGE_WIDTH);
    localparam int ROW_W        = $clog2(IMAGE_HEIGHT);
    localparam int PIX_W        = 8;
    localparam int POS_W        = 6;
    localparam int WEIGHT_W     = 16;
    localparam int TAPS_PER_ROW = 3;
    localparam int CFG_W        = WEIGHT_W * TAPS_PER_ROW;
    localparam int CFG_INDEX_W  = 2;

    // A signed weight times a zero-extended pixel, then sums of three.
    localparam int PROD_W    = WEIGHT_W + PIX_W + 1;
    localparam int ROW_SUM_W = PROD_W + 2;
    localparam int ACC_W     = ROW_SUM_W + 2;

    localparam int OUT_TDATA_W = 24;
    localparam int TDATA_PAD_W = OUT_TDATA_W - PIX_W - 2 * POS_W;
    localparam int PIX_MAX     = 255;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KERNEL_TOP    = 2'd0,
        REG_KERNEL_MIDDLE = 2'd1,
        REG_KERNEL_BOTTOM = 2'd2
    } t_cfg_index;

    // Load enables of the pipeline, handed from the top level to the cells.
    typedef struct packed {
        logic accept;     // an input item is taken this cycle
        logic load_prod;  // product registers load
        logic load_sum;   // row sum registers load
    } t_pipe_ctrl;

    typedef struct packed {
        t_pos row;
        t_pos col;
        logic last;
    } t_meta;

endpackage

// File: src/c3c_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Has no dependencies.
module c3c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/c3c_cell.sv
// One kernel row cell: two window taps, three weight multiplies and a row sum.
// Depends on c3c_pkg.
module c3c_cell (
    input  logic                               i_clk,
    input  c3c_pkg::t_pipe_ctrl                i_ctrl,
    input  logic [c3c_pkg::CFG_W-1:0]          i_weights,
    input  c3c_pkg::t_pix                      i_right,
    output logic signed [c3c_pkg::ROW_SUM_W-1:0] o_row_sum
);

    c3c_pkg::t_pix                          r_tap_left;
    c3c_pkg::t_pix                          r_tap_mid;
    c3c_pkg::t_pix                          pix     [c3c_pkg::TAPS_PER_ROW];
    logic signed [c3c_pkg::WEIGHT_W-1:0]    weight  [c3c_pkg::TAPS_PER_ROW];
    logic signed [c3c_pkg::PROD_W-1:0]      n_prod  [c3c_pkg::TAPS_PER_ROW];
    logic signed [c3c_pkg::PROD_W-1:0]      r_prod  [c3c_pkg::TAPS_PER_ROW];
    logic signed [c3c_pkg::ROW_SUM_W-1:0]   r_row_sum;

    always_comb begin
        pix[0] = r_tap_left;
        pix[1] = r_tap_mid;
        pix[2] = i_right;
        for (int k = 0; k < c3c_pkg::TAPS_PER_ROW; k++) begin
            weight[k] = $signed(i_weights[k*c3c_pkg::WEIGHT_W +: c3c_pkg::WEIGHT_W]);
            n_prod[k] = weight[k] * $signed({1'b0, pix[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_tap_left <= r_tap_mid;
            r_tap_mid  <= i_right;
        end
        if (i_ctrl.load_prod) begin
            for (int k = 0; k < c3c_pkg::TAPS_PER_ROW; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
        if (i_ctrl.load_sum) begin
            r_row_sum <= c3c_pkg::ROW_SUM_W'(r_prod[0])
                       + c3c_pkg::ROW_SUM_W'(r_prod[1])
                       + c3c_pkg::ROW_SUM_W'(r_prod[2]);
        end
    end

    assign o_row_sum = r_row_sum;

endmodule

// File: src/c3c_out.sv
// Final adder, clamp to 8 bits and the output register of the result channel.
// Depends on c3c_pkg.
module c3c_out (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic                                 i_valid,
    input  c3c_pkg::t_meta                       i_meta,
    input  logic signed [c3c_pkg::ROW_SUM_W-1:0] i_sum_top,
    input  logic signed [c3c_pkg::ROW_SUM_W-1:0] i_sum_mid,
    input  logic signed [c3c_pkg::ROW_SUM_W-1:0] i_sum_bot,
    output logic                                 o_valid,
    output c3c_pkg::t_pix                        o_value,
    output c3c_pkg::t_meta                       o_meta
);

    logic signed [c3c_pkg::ACC_W-1:0] acc;
    logic [c3c_pkg::ACC_W-1:0]        mag;
    c3c_pkg::t_pix                    n_value;
    logic                             r_valid;
    c3c_pkg::t_pix                    r_value;
    c3c_pkg::t_meta                   r_meta;

    always_comb begin
        acc = c3c_pkg::ACC_W'(i_sum_top) + c3c_pkg::ACC_W'(i_sum_mid)
            + c3c_pkg::ACC_W'(i_sum_bot);
        mag = c3c_pkg::ACC_W'($unsigned(acc) >> c3c_pkg::COEF_FRAC_BITS);
        // Negative sums give zero; otherwise the fraction is truncated and capped.
        if (acc[c3c_pkg::ACC_W-1]) begin
            n_value = '0;
        end else if (|mag[c3c_pkg::ACC_W-1:c3c_pkg::PIX_W]) begin
            n_value = c3c_pkg::PIX_W'(c3c_pkg::PIX_MAX);
        end else begin
            n_value = mag[c3c_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
        if (i_load) begin
            r_value <= n_value;
            r_meta  <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_meta  = r_meta;

endmodule

// File: src/conv3x3_clamp_u8.sv
// Top level of the streaming 3x3 convolution with clamping to 8 bits.
// Depends on c3c_pkg, c3c_ram, c3c_cell, c3c_out and the assertion header.
//
// Pixels enter on the s_axis channel in raster order, one item per pixel,
// with s_axis_tuser set on the first pixel of a frame. Each pixel whose
// window centre lies inside the frame border yields one item on m_axis:
// the clamped weighted sum, the centre position and tlast on the last
// interior pixel. Border positions yield nothing.
// The three kernel rows are written through the cfg channel (index 0 top, 1 middle,
// 2 bottom); the user writes them only while the block is idle, which the block does
// not enforce; o_cfg_ready is always high. Throughput is one pixel per cycle while
// the receiver does not stall: the two previous rows sit in one dual-width line RAM
// whose read address is the next column, and three row cells do their multiplies in
// parallel. An accepted pixel's result passes the product, row sum and output
// registers on its way to m_axis. When the receiver stalls, the result waits in the
// output register and the two inner stages keep filling; input stalls only once all
// three are full. Reset clears the counters, pipeline valid flags and kernel
// registers; the line RAM needs no clearing: unwritten entries never reach a result.
`include "conv3x3_clamp_u8_assert.svh"

module conv3x3_clamp_u8 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [c3c_pkg::PIX_W-1:0]           s_axis_tdata,  // [7:0] pixel_value
    input  logic                                s_axis_tuser,  // [0] frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] filtered_value, [13:8] centre_row, [19:14] centre_column, [23:20] zero
    output logic [c3c_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,  // frame_end
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [c3c_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [c3c_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [c3c_pkg::CFG_W-1:0]          r_kernel_top;
    logic [c3c_pkg::CFG_W-1:0]          r_kernel_mid;
    logic [c3c_pkg::CFG_W-1:0]          r_kernel_bot;

    logic [c3c_pkg::ROW_W-1:0]          r_row;
    logic [c3c_pkg::COL_W-1:0]          r_col;
    logic [c3c_pkg::ROW_W-1:0]          n_row;
    logic [c3c_pkg::COL_W-1:0]          n_col;
    logic [c3c_pkg::ROW_W-1:0]          row_eff;
    logic [c3c_pkg::COL_W-1:0]          col_eff;

    logic                               r_v1;
    logic                               r_v2;
    c3c_pkg::t_meta                     r_meta1;
    c3c_pkg::t_meta                     r_meta2;
    c3c_pkg::t_meta                     n_meta;
    logic                               emit;
    logic                               load_out;
    logic                               out_valid;
    c3c_pkg::t_pix                      out_value;
    c3c_pkg::t_meta                     out_meta;
    c3c_pkg::t_pipe_ctrl                ctrl;

    c3c_pkg::t_pix                      pixel;
    c3c_pkg::t_pix                      up1;
    c3c_pkg::t_pix                      up2;
    logic [2*c3c_pkg::PIX_W-1:0]        ram_rdata;

    logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_top;
    logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_mid;
    logic signed [c3c_pkg::ROW_SUM_W-1:0] sum_bot;

    // Pipeline flow: a stage loads when it is empty or its successor moves on.
    always_comb begin
        load_out       = !out_valid || m_axis_tready;
        ctrl.load_sum  = !r_v2 || load_out;
        ctrl.load_prod = !r_v1 || ctrl.load_sum;
        ctrl.accept    = s_axis_tvalid && ctrl.load_prod;
    end

    assign s_axis_tready = ctrl.load_prod;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        pixel   = s_axis_tdata;
        row_eff = s_axis_tuser ? '0 : r_row;
        col_eff = s_axis_tuser ? '0 : r_col;
        n_row   = r_row;
        n_col   = r_col;
        if (ctrl.accept) begin
            if (col_eff == c3c_pkg::COL_W'(c3c_pkg::IMAGE_WIDTH - 1)) begin
                n_col = '0;
                if (row_eff == c3c_pkg::ROW_W'(c3c_pkg::IMAGE_HEIGHT - 1)) begin
                    n_row = '0;
                end else begin
                    n_row = row_eff + 1'b1;
                end
            end else begin
                n_col = col_eff + 1'b1;
                n_row = row_eff;
            end
        end
        emit        = (row_eff >= c3c_pkg::ROW_W'(2)) && (col_eff >= c3c_pkg::COL_W'(2));
        n_meta.row  = c3c_pkg::t_pos'(row_eff - 1'b1);
        n_meta.col  = c3c_pkg::t_pos'(col_eff - 1'b1);
        n_meta.last = (row_eff == c3c_pkg::ROW_W'(c3c_pkg::IMAGE_HEIGHT - 1))
                   && (col_eff == c3c_pkg::COL_W'(c3c_pkg::IMAGE_WIDTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_top <= '0;
            r_kernel_mid <= '0;
            r_kernel_bot <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                c3c_pkg::REG_KERNEL_TOP:    r_kernel_top <= i_cfg_data;
                c3c_pkg::REG_KERNEL_MIDDLE: r_kernel_mid <= i_cfg_data;
                c3c_pkg::REG_KERNEL_BOTTOM: r_kernel_bot <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            if (ctrl.load_prod) begin
                r_v1 <= ctrl.accept && emit;
            end
            if (ctrl.load_sum) begin
                r_v2 <= r_v1;
            end
        end
        if (ctrl.load_prod) begin
            r_meta1 <= n_meta;
        end
        if (ctrl.load_sum) begin
            r_meta2 <= r_meta1;
        end
    end

    // Low byte is the row above (line A), high byte the row two above (line B).
    // The read address is the next column, so the data is ready when that pixel comes.
    c3c_ram #(
        .WIDTH (2 * c3c_pkg::PIX_W),
        .DEPTH (c3c_pkg::IMAGE_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.accept),
        .i_waddr (col_eff),
        .i_wdata ({up1, pixel}),
        .i_raddr (n_col),
        .o_rdata (ram_rdata)
    );

    assign up1 = ram_rdata[c3c_pkg::PIX_W-1:0];
    assign up2 = ram_rdata[2*c3c_pkg::PIX_W-1:c3c_pkg::PIX_W];

    c3c_cell u_cell_top (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_weights (r_kernel_top),
        .i_right   (up2),
        .o_row_sum (sum_top)
    );

    c3c_cell u_cell_mid (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_weights (r_kernel_mid),
        .i_right   (up1),
        .o_row_sum (sum_mid)
    );

    c3c_cell u_cell_bot (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_weights (r_kernel_bot),
        .i_right   (pixel),
        .o_row_sum (sum_bot)
    );

    c3c_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load_out),
        .i_valid   (r_v2),
        .i_meta    (r_meta2),
        .i_sum_top (sum_top),
        .i_sum_mid (sum_mid),
        .i_sum_bot (sum_bot),
        .o_valid   (out_valid),
        .o_value   (out_value),
        .o_meta    (out_meta)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {{c3c_pkg::TDATA_PAD_W{1'b0}}, out_meta.col, out_meta.row, out_value};
    assign m_axis_tlast  = out_meta.last;

    `C3C_ASSERT_NEXT(a_frame_start_restarts, ctrl.accept && s_axis_tuser,
        r_row == '0 && r_col == c3c_pkg::COL_W'(1))
    `C3C_ASSERT_NOW(a_empty_pipe_takes_input, !r_v1, s_axis_tready)
    `C3C_ASSERT_NEXT(a_no_item_no_product, ctrl.load_prod && !ctrl.accept, !r_v1)
    `C3C_ASSERT_NOW(a_last_at_final_centre, m_axis_tvalid && m_axis_tlast,
        out_meta.row == c3c_pkg::t_pos'(c3c_pkg::IMAGE_HEIGHT - 2)
        && out_meta.col == c3c_pkg::t_pos'(c3c_pkg::IMAGE_WIDTH - 2))

endmodule

// File: dv/conv3x3_clamp_u8_tb.sv
// Self-checking testbench of the streaming 3x3 convolution conv3x3_clamp_u8.
// Depends on c3c_pkg and the block's RTL; it drives pixel frames and kernel writes
// and checks every result against a predictor held in this file.
`timescale 1ns / 1ps

module conv3x3_clamp_u8_tb;

    localparam int          KERNEL_ROWS    = 3;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RANDOM_PIXELS  = 1200;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int          REPORT_LIMIT   = 100;

    typedef logic [c3c_pkg::CFG_W-1:0] t_kernel_row;

    typedef struct {
        c3c_pkg::t_pix value;
        c3c_pkg::t_pos row;
        c3c_pkg::t_pos col;
        logic          last;
    } t_conv_result;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    c3c_pkg::t_pix                   s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    logic [c3c_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [c3c_pkg::CFG_INDEX_W-1:0] i_cfg_index   = c3c_pkg::REG_KERNEL_TOP;
    t_kernel_row                     i_cfg_data    = '0;

    // Predictor state: kernel, two line stores, window taps and the position
    // of the next pixel.
    t_kernel_row   kernel_rows [KERNEL_ROWS];
    c3c_pkg::t_pix line_above [c3c_pkg::IMAGE_WIDTH];
    c3c_pkg::t_pix line_two_above [c3c_pkg::IMAGE_WIDTH];
    c3c_pkg::t_pix window_taps [6];
    int            row_pos;
    int            col_pos;
    t_conv_result  filtered_due [$];

    int unsigned  mismatches;
    int unsigned  pixels_sent;
    int unsigned  cycles;
    int unsigned  tx_gap_odds;
    int unsigned  rx_stall_odds;

    conv3x3_clamp_u8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("conv3x3_clamp_u8_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // --------------------------------------------------------------- predictor

    function automatic t_kernel_row kernel_row(input int left, input int mid, input int right);
        return {16'(right), 16'(mid), 16'(left)};
    endfunction

    function automatic longint row_dot(input t_kernel_row k, input c3c_pkg::t_pix a,
                                       input c3c_pkg::t_pix b, input c3c_pkg::t_pix c);
        longint wa, wb, wc;
        wa = longint'($signed(k[15:0]));
        wb = longint'($signed(k[31:16]));
        wc = longint'($signed(k[47:32]));
        return wa * longint'(a) + wb * longint'(b) + wc * longint'(c);
    endfunction

    function automatic void convolve_pixel(input c3c_pkg::t_pix px, input logic start);
        c3c_pkg::t_pix above1;
        c3c_pkg::t_pix above2;
        longint        acc;
        t_conv_result  res;
        if (start) begin
            row_pos = 0;
            col_pos = 0;
        end
        above1 = line_above[col_pos];
        above2 = line_two_above[col_pos];
        // The incoming pixel completes the window centred one row up and one column left.
        if (row_pos >= 2 && col_pos >= 2) begin
            acc = row_dot(kernel_rows[c3c_pkg::REG_KERNEL_TOP],
                          window_taps[0], window_taps[1], above2)
                + row_dot(kernel_rows[c3c_pkg::REG_KERNEL_MIDDLE],
                          window_taps[2], window_taps[3], above1)
                + row_dot(kernel_rows[c3c_pkg::REG_KERNEL_BOTTOM],
                          window_taps[4], window_taps[5], px);
            if (acc < 0)
                res.value = '0;
            else if ((acc >>> c3c_pkg::COEF_FRAC_BITS) > c3c_pkg::PIX_MAX)
                res.value = c3c_pkg::t_pix'(c3c_pkg::PIX_MAX);
            else
                res.value = c3c_pkg::t_pix'(acc >>> c3c_pkg::COEF_FRAC_BITS);
            res.row  = c3c_pkg::t_pos'(row_pos - 1);
            res.col  = c3c_pkg::t_pos'(col_pos - 1);
            res.last = (row_pos == c3c_pkg::IMAGE_HEIGHT - 1)
                    && (col_pos == c3c_pkg::IMAGE_WIDTH - 1);
            filtered_due.push_back(res);
        end
        line_two_above[col_pos] = above1;
        line_above[col_pos]     = px;
        window_taps[0] = window_taps[1];
        window_taps[1] = above2;
        window_taps[2] = window_taps[3];
        window_taps[3] = above1;
        window_taps[4] = window_taps[5];
        window_taps[5] = px;
        col_pos++;
        if (col_pos >= c3c_pkg::IMAGE_WIDTH) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= c3c_pkg::IMAGE_HEIGHT)
                row_pos = 0;
        end
    endfunction

    // ----------------------------------------------------------------- checker

    always @(posedge i_clk) begin : check_output
        t_conv_result due;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (filtered_due.size() == 0) begin
                report_mismatch($sformatf("result with none awaited, tdata %h tlast %b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                due = filtered_due.pop_front();
                if (m_axis_tdata[7:0] !== due.value)
                    report_mismatch($sformatf("value at (%0d,%0d): got %0d, want %0d",
                                              due.row, due.col, m_axis_tdata[7:0], due.value));
                if (m_axis_tdata[13:8] !== due.row)
                    report_mismatch($sformatf("row: got %0d, want %0d",
                                              m_axis_tdata[13:8], due.row));
                if (m_axis_tdata[19:14] !== due.col)
                    report_mismatch($sformatf("column: got %0d, want %0d",
                                              m_axis_tdata[19:14], due.col));
                if (m_axis_tdata[c3c_pkg::OUT_TDATA_W-1:20] !== '0)
                    report_mismatch($sformatf("padding bits not zero: tdata %h", m_axis_tdata));
                if (m_axis_tlast !== due.last)
                    report_mismatch($sformatf("tlast at (%0d,%0d): got %b, want %b",
                                              due.row, due.col, m_axis_tlast, due.last));
            end
        end
    end

    // Receiver stalls in bursts at random; odds of zero hold tready high.
    initial begin : rx_backpressure
        int unsigned hold;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
                hold = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------ driver

    task automatic send_pixel(input c3c_pkg::t_pix px, input logic start);
        if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        convolve_pixel(px, start);
        pixels_sent++;
    endtask

    // Called in the step where the last item was taken, so tvalid sees one update.
    task automatic end_stream();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (filtered_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_kernel(input t_kernel_row top, input t_kernel_row mid,
                               input t_kernel_row bot);
        t_kernel_row         vals [KERNEL_ROWS];
        c3c_pkg::t_cfg_index idx;
        vals = '{top, mid, bot};
        idx  = c3c_pkg::REG_KERNEL_TOP;
        for (int n = 0; n < KERNEL_ROWS; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[n];
            do @(posedge i_clk); while (!o_cfg_ready);
            kernel_rows[idx] = vals[n];
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic c3c_pkg::t_pix any_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return c3c_pkg::t_pix'(c3c_pkg::PIX_MAX);
            default: return c3c_pkg::t_pix'($urandom_range(0, c3c_pkg::PIX_MAX));
        endcase
    endfunction

    function automatic int signed_rand(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_frame(input int count, input logic mark_start);
        for (int i = 0; i < count; i++)
            send_pixel(any_pixel(), mark_start && i == 0);
    endtask

    task automatic load_random_kernel();
        t_kernel_row rows [KERNEL_ROWS];
        int          style;
        style = $urandom_range(0, 3);
        for (int n = 0; n < KERNEL_ROWS; n++) begin
            case (style)
                0:       rows[n] = t_kernel_row'({$urandom(), $urandom()});
                1:       rows[n] = kernel_row(signed_rand(300), signed_rand(300), signed_rand(300));
                2:       rows[n] = kernel_row($urandom_range(0, 64), $urandom_range(0, 64),
                                              $urandom_range(0, 64));
                default: rows[n] = kernel_row(signed_rand(128), signed_rand(128), signed_rand(128));
            endcase
        end
        // Sharpening style: a strong positive centre against small neighbours.
        if (style == 3)
            rows[1][31:16] = 16'($urandom_range(256, 1024));
        load_kernel(rows[0], rows[1], rows[2]);
    endtask

    // ------------------------------------------------------------------- tests

    // Pass-through kernel; the centre row walks single ones and zeros, the extremes and 55/aa.
    task automatic test_identity_extremes();
        c3c_pkg::t_pix px;
        int            c;
        tx_gap_odds   = 5;
        rx_stall_odds = 5;
        load_kernel('0, kernel_row(0, 256, 0), '0);
        for (int i = 0; i < 3 * c3c_pkg::IMAGE_WIDTH; i++) begin
            c = i % c3c_pkg::IMAGE_WIDTH;
            if (i / c3c_pkg::IMAGE_WIDTH != 1 || c > 19)
                px = any_pixel();
            else if (c < 8)
                px = c3c_pkg::t_pix'(1 << c);
            else if (c < 16)
                px = ~c3c_pkg::t_pix'(1 << (c - 8));
            else if (c == 16)
                px = '0;
            else if (c == 17)
                px = c3c_pkg::t_pix'(c3c_pkg::PIX_MAX);
            else if (c == 18)
                px = 8'h55;
            else
                px = 8'haa;
            send_pixel(px, i == 0);
        end
        end_stream();
        drain_results();
    endtask

    // Saturating, all-negative, mixed-sign, blur, edge and tiny-fraction kernels.
    task automatic test_kernel_extremes();
        t_kernel_row   sets [6][KERNEL_ROWS];
        c3c_pkg::t_pix px;
        sets[0] = '{kernel_row(32767, 32767, 32767), kernel_row(32767, 32767, 32767),
                    kernel_row(32767, 32767, 32767)};
        sets[1] = '{kernel_row(-32768, -32768, -32768), kernel_row(-32768, -32768, -32768),
                    kernel_row(-32768, -32768, -32768)};
        sets[2] = '{kernel_row(32767, 32767, 32767), '0,
                    kernel_row(-32768, -32768, -32768)};
        sets[3] = '{kernel_row(28, 28, 28), kernel_row(28, 28, 28), kernel_row(28, 28, 28)};
        sets[4] = '{kernel_row(-256, -256, -256), kernel_row(-256, 2048, -256),
                    kernel_row(-256, -256, -256)};
        sets[5] = '{kernel_row(1, 1, 1), kernel_row(1, 1, 1), kernel_row(1, 1, 1)};
        tx_gap_odds   = 6;
        rx_stall_odds = 4;
        for (int s = 0; s < 6; s++) begin
            load_kernel(sets[s][0], sets[s][1], sets[s][2]);
            // Sparse pixels so that some windows are all zero.
            for (int i = 0; i < 3 * c3c_pkg::IMAGE_WIDTH; i++) begin
                px = ($urandom_range(0, 2) == 0) ? any_pixel() : '0;
                send_pixel(px, i == 0);
            end
            end_stream();
            drain_results();
        end
    endtask

    // A single unit weight at each of the nine positions pins down the window order.
    task automatic test_tap_alignment();
        t_kernel_row rows [KERNEL_ROWS];
        tx_gap_odds   = 3;
        rx_stall_odds = 8;
        for (int p = 0; p < 9; p++) begin
            rows = '{'0, '0, '0};
            rows[p / 3][16 * (p % 3) +: 16] = 16'h0100;
            load_kernel(rows[0], rows[1], rows[2]);
            send_frame(2 * c3c_pkg::IMAGE_WIDTH + 20, 1'b1);
            end_stream();
            drain_results();
        end
    endtask

    // New frames begin mid-row, mid-frame, on consecutive pixels and at a row start.
    task automatic test_frame_restart();
        tx_gap_odds   = 4;
        rx_stall_odds = 4;
        load_kernel(kernel_row(signed_rand(200), signed_rand(200), signed_rand(200)),
                    kernel_row(signed_rand(200), 300, signed_rand(200)),
                    kernel_row(signed_rand(200), signed_rand(200), signed_rand(200)));
        send_frame(2 * c3c_pkg::IMAGE_WIDTH + 10, 1'b1);
        send_frame(3 * c3c_pkg::IMAGE_WIDTH + 30, 1'b1);
        send_frame(5, 1'b1);
        send_frame(1, 1'b1);
        send_frame(1, 1'b1);
        send_frame(c3c_pkg::IMAGE_WIDTH, 1'b1);
        send_frame(3 * c3c_pkg::IMAGE_WIDTH + 7, 1'b1);
        end_stream();
        drain_results();
    endtask

    // One whole frame for tlast, then a frame that starts by wrapping with no mark.
    task automatic test_full_frame_wrap();
        tx_gap_odds   = 10;
        rx_stall_odds = 10;
        load_kernel(kernel_row($urandom_range(0, 40), $urandom_range(0, 40), 30),
                    kernel_row(25, $urandom_range(0, 60), $urandom_range(0, 40)),
                    kernel_row($urandom_range(0, 40), 20, $urandom_range(0, 40)));
        for (int i = 0; i < c3c_pkg::IMAGE_WIDTH * c3c_pkg::IMAGE_HEIGHT; i++) begin
            // Halfway the sender holds off until every awaited result is out.
            if (i == 2000) begin
                end_stream();
                while (filtered_due.size() != 0) @(posedge i_clk);
            end
            send_pixel(any_pixel(), i == 0);
        end
        send_frame(3 * c3c_pkg::IMAGE_WIDTH + 5, 1'b0);
        end_stream();
        drain_results();
    endtask

    // Mostly well-formed frames with random content and kernels; some noise.
    task automatic test_random_stream();
        int unsigned base;
        int unsigned done;
        int          count;
        base = pixels_sent;
        done = 0;
        while (done < RANDOM_PIXELS) begin
            if (done > RANDOM_PIXELS * 3 / 4) begin
                tx_gap_odds   = 0;
                rx_stall_odds = 0;
            end else begin
                tx_gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
                rx_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            end
            if ($urandom_range(0, 2) == 0) begin
                end_stream();
                drain_results();
                load_random_kernel();
            end
            if ($urandom_range(0, 5) == 0) begin
                count = $urandom_range(1, 2 * c3c_pkg::IMAGE_WIDTH);
                for (int i = 0; i < count; i++)
                    send_pixel(any_pixel(), $urandom_range(0, 15) == 0);
            end else begin
                send_frame(3 * c3c_pkg::IMAGE_WIDTH
                           + $urandom_range(0, 2 * c3c_pkg::IMAGE_WIDTH), 1'b1);
            end
            done = pixels_sent - base;
        end
        end_stream();
    endtask

    initial begin : run_tests
        for (int n = 0; n < KERNEL_ROWS; n++)
            kernel_rows[n] = '0;
        for (int n = 0; n < c3c_pkg::IMAGE_WIDTH; n++) begin
            line_above[n]     = '0;
            line_two_above[n] = '0;
        end
        for (int n = 0; n < 6; n++)
            window_taps[n] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_extremes();
        test_kernel_extremes();
        test_tap_alignment();
        test_frame_restart();
        test_full_frame_wrap();
        test_random_stream();

        drain_results();
        if (mismatches == 0)
            $display("conv3x3_clamp_u8_tb: done, clean");
        else
            $display("conv3x3_clamp_u8_tb: done, errors");
        $finish;
    end

endmodule
